FILE: design/address_type_flag_scanner_macros.svh
// Assertion helpers for the flag scanner. Each expects clk and rst in scope.
`ifndef ADDRESS_TYPE_FLAG_SCANNER_MACROS_SVH
`define ADDRESS_TYPE_FLAG_SCANNER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/atfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atfs_pkg;

  // Block configuration
  localparam int TABLE_DEPTH = 65536;
  localparam int FLAG_WIDTH  = 8;
  localparam int DEST_BIT    = 0;
  localparam int ASM_BIT     = 1;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int ADDR_W    = 16;
  localparam int FLAG_IN_W = 8;
  localparam int CNT_OUT_W = 17;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  // A flag bit outside FLAG_WIDTH is masked off and never stored
  localparam bit DEST_LIVE = (DEST_BIT < FLAG_WIDTH);
  localparam bit ASM_LIVE  = (ASM_BIT < FLAG_WIDTH);

  // Memory packing: 64 entries per word, dest and asm bit per entry
  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int WORDS      = TABLE_DEPTH / SLOTS;
  localparam int WIDX_W     = $clog2(WORDS);
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

  // Word evaluation tree: groups of eight entries
  localparam int GROUP  = 8;
  localparam int GROUPS = SLOTS / GROUP;
  localparam int GIDX_W = $clog2(GROUP);
  localparam int GSEL_W = $clog2(GROUPS);
  localparam int GCNT_W = $clog2(GROUP + 1);

  typedef struct packed {
    logic [SLOTS-1:0] asm_bits;
    logic [SLOTS-1:0] dest_bits;
  } word_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_CNT_W-1:0] cnt;
  } eval_t;

endpackage

`default_nettype wire

FILE: design/atfs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface atfs_req_if;
  logic                            valid;
  logic                            ready;
  logic [atfs_pkg::REQ_W-1:0]      req_type;
  logic [atfs_pkg::ADDR_W-1:0]     address;
  logic [atfs_pkg::FLAG_IN_W-1:0]  flag_bits;

  modport source (output valid, req_type, address, flag_bits, input ready);
  modport sink   (input valid, req_type, address, flag_bits, output ready);
endinterface

`default_nettype wire

FILE: design/atfs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface atfs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [atfs_pkg::ADDR_W-1:0]     position;
  logic [atfs_pkg::CNT_OUT_W-1:0]  dest_count;

  modport source (output valid, found, position, dest_count, input ready);
  modport sink   (input valid, found, position, dest_count, output ready);
endinterface

`default_nettype wire

FILE: design/address_type_flag_scanner.sv
// Address type flag scanner. Keeps a destination flag and an assembled flag
// for each of TABLE_DEPTH addresses, packed 64 entries to a word of one
// synchronous memory (the other flag bits are never observable and are not
// kept). After reset the block sweeps all WORDS (1024) memory words to zero,
// one word a cycle, with req held not ready. Every request gives one
// response beat. A mark reads the word, writes it back modified, then
// responds. A find or count reads one word per cycle from the start word
// onward; a find stops at the word holding the first pending entry. The
// single memory read port sets that rate. Requests are taken one at a time; a
// finished response sits in an output register, so the next request is
// accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "address_type_flag_scanner_macros.svh"

module address_type_flag_scanner (
  input  wire logic    clk,
  input  wire logic    rst,
  atfs_req_if.sink     req,
  atfs_rsp_if.source   rsp
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [atfs_pkg::WIDX_W-1:0] LAST_WORD = atfs_pkg::WIDX_W'(atfs_pkg::WORDS - 1);

  // Control state
  logic [2:0]                       state;
  logic [atfs_pkg::WIDX_W-1:0]      clr_idx;
  logic                             out_valid;

  // Per-request working registers
  logic [atfs_pkg::REQ_W-1:0]       op;
  logic [atfs_pkg::WIDX_W-1:0]      data_idx;
  logic [atfs_pkg::SLOT_W-1:0]      start_slot;
  logic                             first;
  logic [atfs_pkg::CNT_W-1:0]       acc;
  logic                             mark_dest;
  logic                             mark_asm;
  logic                             res_found;
  logic [atfs_pkg::ADDR_W-1:0]      res_pos;
  logic [atfs_pkg::CNT_OUT_W-1:0]   res_cnt;
  logic                             out_found;
  logic [atfs_pkg::ADDR_W-1:0]      out_pos;
  logic [atfs_pkg::CNT_OUT_W-1:0]   out_cnt;

  // Flag memory
  atfs_pkg::word_t                  mem [atfs_pkg::WORDS];
  atfs_pkg::word_t                  rd_data;
  atfs_pkg::word_t                  wr_data;
  logic                             rd_en;
  logic [atfs_pkg::WIDX_W-1:0]      rd_addr;
  logic                             wr_en;
  logic [atfs_pkg::WIDX_W-1:0]      wr_addr;

  logic                             accept;
  logic                             in_range;
  logic                             known_req;
  logic [atfs_pkg::WIDX_W-1:0]      in_word;
  logic                             scan_last;
  logic                             scan_hit;
  logic                             scan_done;
  logic                             load_out;
  logic [atfs_pkg::CNT_W-1:0]       acc_next;
  atfs_pkg::eval_t                  ev;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = ({1'b0, req.address} < (atfs_pkg::ADDR_W + 1)'(atfs_pkg::TABLE_DEPTH));
  assign in_word   = req.address[atfs_pkg::SLOT_W +: atfs_pkg::WIDX_W];
  assign known_req = req.req_type inside {atfs_pkg::REQ_MARK, atfs_pkg::REQ_FIND,
                                          atfs_pkg::REQ_COUNT};

  atfs_word_eval u_eval (
    .word       (rd_data),
    .start_slot (start_slot),
    .first      (first),
    .res        (ev)
  );

  assign scan_last = (data_idx == LAST_WORD);
  assign scan_hit  = (op == atfs_pkg::REQ_FIND) && ev.hit;
  assign scan_done = scan_last || scan_hit;
  assign acc_next  = acc + atfs_pkg::CNT_W'(ev.cnt);
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  // Read port: first word on accept, then prefetch the next word while scanning
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_word;
    if (accept && in_range && known_req) begin
      rd_en = 1'b1;
    end else if (state == S_SCAN && !scan_done) begin
      rd_en   = 1'b1;
      rd_addr = data_idx + atfs_pkg::WIDX_W'(1);
    end
  end

  // Write port: clearing sweep or mark write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = data_idx;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if (state == S_MARK) begin
      wr_en             = 1'b1;
      wr_data.dest_bits = rd_data.dest_bits |
                          (atfs_pkg::SLOTS'(mark_dest) << start_slot);
      wr_data.asm_bits  = rd_data.asm_bits |
                          (atfs_pkg::SLOTS'(mark_asm) << start_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a finished answer, or drop the output beat once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + atfs_pkg::WIDX_W'(1);
          if (clr_idx == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op         <= req.req_type;
            data_idx   <= in_word;
            start_slot <= req.address[atfs_pkg::SLOT_W-1:0];
            first      <= 1'b1;
            acc        <= '0;
            mark_dest  <= atfs_pkg::DEST_LIVE && req.flag_bits[atfs_pkg::DEST_BIT];
            mark_asm   <= atfs_pkg::ASM_LIVE && req.flag_bits[atfs_pkg::ASM_BIT];
            res_found  <= 1'b0;
            res_pos    <= '0;
            res_cnt    <= '0;
            case (req.req_type) inside
              atfs_pkg::REQ_MARK: begin
                state <= in_range ? S_MARK : S_DONE;
              end
              atfs_pkg::REQ_FIND, atfs_pkg::REQ_COUNT: begin
                state <= in_range ? S_SCAN : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MARK: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          // One word per cycle; hold the start mask for the first word only
          first <= 1'b0;
          acc   <= acc_next;
          if (scan_done) begin
            res_found <= scan_hit;
            res_pos   <= scan_hit ? atfs_pkg::ADDR_W'({data_idx, ev.hit_idx}) : '0;
            res_cnt   <= (op == atfs_pkg::REQ_COUNT) ?
                         atfs_pkg::CNT_OUT_W'(acc_next) : '0;
            state     <= S_DONE;
          end else begin
            data_idx <= data_idx + atfs_pkg::WIDX_W'(1);
          end
        end
        S_DONE: begin
          // Advance into the output register when it is free
          if (load_out) begin
            out_found <= res_found;
            out_pos   <= res_pos;
            out_cnt   <= res_cnt;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.position   = out_pos;
  assign rsp.dest_count = out_cnt;

  `ATFS_ASSERT_NOW(a_scan_advance,
    (state == S_SCAN) && ($past(state) == S_SCAN),
    data_idx == atfs_pkg::WIDX_W'($past(data_idx) + atfs_pkg::WIDX_W'(1)),
    "scan word index did not advance by one")
  `ATFS_ASSERT_NOW(a_port_split, rd_en && wr_en, rd_addr != wr_addr,
    "read and write hit the same word")
  `ATFS_ASSERT_NOW(a_found_no_count, rsp.valid && rsp.found, rsp.dest_count == '0,
    "find beat carries a count")
  `ATFS_ASSERT_NOW(a_pos_in_table, rsp.valid && rsp.found,
    {1'b0, rsp.position} < (atfs_pkg::ADDR_W + 1)'(atfs_pkg::TABLE_DEPTH),
    "found position beyond table")

endmodule

`default_nettype wire

FILE: design/atfs_word_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Evaluate one memory word: first pending entry and destination count,
// ignoring entries below start_slot on the first word of a scan.
module atfs_word_eval (
  input  atfs_pkg::word_t                    word,
  input  logic [atfs_pkg::SLOT_W-1:0]        start_slot,
  input  logic                               first,
  output atfs_pkg::eval_t                    res
);

  logic [atfs_pkg::SLOTS-1:0]  keep;
  logic [atfs_pkg::SLOTS-1:0]  pend;
  logic [atfs_pkg::SLOTS-1:0]  dest;
  logic [atfs_pkg::GROUPS-1:0] g_hit;
  logic [atfs_pkg::GIDX_W-1:0] g_idx [atfs_pkg::GROUPS];
  logic [atfs_pkg::GCNT_W-1:0] g_cnt [atfs_pkg::GROUPS];

  assign keep = first ? ({atfs_pkg::SLOTS{1'b1}} << start_slot) : {atfs_pkg::SLOTS{1'b1}};
  assign pend = word.dest_bits & ~word.asm_bits & keep;
  assign dest = word.dest_bits & keep;

  // First level: per group of eight entries
  always_comb begin
    for (int g = 0; g < atfs_pkg::GROUPS; g++) begin
      g_hit[g] = |pend[g*atfs_pkg::GROUP +: atfs_pkg::GROUP];
      g_idx[g] = '0;
      g_cnt[g] = '0;
      for (int j = atfs_pkg::GROUP - 1; j >= 0; j--) begin
        if (pend[g*atfs_pkg::GROUP + j]) begin
          g_idx[g] = atfs_pkg::GIDX_W'(j);
        end
      end
      for (int j = 0; j < atfs_pkg::GROUP; j++) begin
        g_cnt[g] = g_cnt[g] + atfs_pkg::GCNT_W'(dest[g*atfs_pkg::GROUP + j]);
      end
    end
  end

  // Second level: combine the groups, lowest hit wins
  always_comb begin
    res.hit     = |g_hit;
    res.hit_idx = '0;
    res.cnt     = '0;
    for (int g = atfs_pkg::GROUPS - 1; g >= 0; g--) begin
      if (g_hit[g]) begin
        res.hit_idx = {atfs_pkg::GSEL_W'(g), g_idx[g]};
      end
    end
    for (int g = 0; g < atfs_pkg::GROUPS; g++) begin
      res.cnt = res.cnt + atfs_pkg::SLOT_CNT_W'(g_cnt[g]);
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import atfs_pkg::*;

  // Request code that the block must treat as a no-op with an all-zero answer.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Flag masks as the table stores them.
  localparam bit [31:0] FLAG_KEEP = 32'hFFFF_FFFF >> (32 - FLAG_WIDTH);
  localparam bit [31:0] DEST_FLAG = 32'd1 << DEST_BIT;
  localparam bit [31:0] ASM_FLAG  = 32'd1 << ASM_BIT;
  localparam bit [31:0] PAIR_FLAGS = DEST_FLAG | ASM_FLAG;
  localparam logic [FLAG_IN_W-1:0] DEST_BYTE = FLAG_IN_W'(DEST_FLAG);
  localparam logic [FLAG_IN_W-1:0] ASM_BYTE  = FLAG_IN_W'(ASM_FLAG);

  // Base of the address window where most random traffic lands, so that
  // searches and counts started there scan at most 64 memory words.
  localparam logic [ADDR_W-1:0] HOT_BASE = 16'hF000;

  // Cycles with no beat on either side before the run is declared hung. The
  // limit is well above a full-table scan, the long receiver hold-off and
  // the post-reset sweep.
  localparam int QUIET_LIMIT = 6000;

  typedef struct packed {
    logic                 found;
    logic [ADDR_W-1:0]    position;
    logic [CNT_OUT_W-1:0] dest_count;
  } scan_result_t;

  logic clk;
  logic rst;

  atfs_req_if req_if ();
  atfs_rsp_if rsp_if ();

  address_type_flag_scanner u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Mirror of the flag table, one word per address, cleared like the block.
  bit [31:0]    flag_mirror [TABLE_DEPTH];
  scan_result_t pending_scan_results [$];
  scan_result_t oldest_result;

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;
  int quiet_cycles;
  int error_count;
  int items_sent;
  int results_seen;
  int n_marks;
  int n_finds;
  int n_find_hits;
  int n_counts;
  int n_unknown;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the mirror and return the answer it must produce.
  function automatic scan_result_t predict_scan_result(input logic [REQ_W-1:0] kind,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [FLAG_IN_W-1:0] flags);
    scan_result_t r;
    int i;
    int n;
    r = '0;
    n = 0;
    case (kind)
      REQ_MARK: begin
        if (int'(addr) < TABLE_DEPTH)
          flag_mirror[addr] = flag_mirror[addr] | (32'(flags) & FLAG_KEEP);
      end
      REQ_FIND: begin
        for (i = int'(addr); i < TABLE_DEPTH; i++) begin
          if ((flag_mirror[i] & PAIR_FLAGS) == DEST_FLAG) begin
            r.found    = 1'b1;
            r.position = ADDR_W'(i);
            break;
          end
        end
      end
      REQ_COUNT: begin
        for (i = int'(addr); i < TABLE_DEPTH; i++)
          if ((flag_mirror[i] & DEST_FLAG) != 0) n++;
        r.dest_count = CNT_OUT_W'(n);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request beat, with a random number of idle cycles in front of
  // it, and record its expected answer once it is taken. Returns at the
  // rising edge of acceptance with valid still high, so the next call can
  // either hold it up for a back-to-back beat or drop it for a gap.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [ADDR_W-1:0] addr,
                              input logic [FLAG_IN_W-1:0] flags);
    int gap;
    scan_result_t want;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.address   <= addr;
    req_if.flag_bits <= flags;
    do @(posedge clk); while (!req_if.ready);
    want = predict_scan_result(kind, addr, flags);
    pending_scan_results.push_back(want);
    items_sent++;
    case (kind)
      REQ_MARK:  n_marks++;
      REQ_FIND: begin
        n_finds++;
        if (want.found) n_find_hits++;
      end
      REQ_COUNT: n_counts++;
      default:   n_unknown++;
    endcase
  endtask

  function automatic logic [ADDR_W-1:0] hot_address();
    return HOT_BASE | ADDR_W'($urandom_range(16'h0FFF));
  endfunction

  // Start a query a short way below an entry of interest.
  function automatic logic [ADDR_W-1:0] start_below(input logic [ADDR_W-1:0] target);
    int s;
    s = int'(target) - int'($urandom_range(300));
    if (s < 0) s = 0;
    return ADDR_W'(s);
  endfunction

  // Receiver: stall at random, or hold off for a counted stretch on request.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        recv_hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every response beat against the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (pending_scan_results.size() == 0) begin
        $display({"%0t: response with nothing outstanding, expected none, got found %0d ",
                  "position %0d count %0d"}, $time, rsp_if.found, rsp_if.position,
                 rsp_if.dest_count);
        error_count++;
      end else begin
        oldest_result = pending_scan_results.pop_front();
        if (rsp_if.found !== oldest_result.found) begin
          $display("%0t: found mismatch, expected %0d, got %0d", $time,
                   oldest_result.found, rsp_if.found);
          error_count++;
        end
        if (rsp_if.position !== oldest_result.position) begin
          $display("%0t: position mismatch, expected %0d, got %0d", $time,
                   oldest_result.position, rsp_if.position);
          error_count++;
        end
        if (rsp_if.dest_count !== oldest_result.dest_count) begin
          $display("%0t: dest_count mismatch, expected %0d, got %0d", $time,
                   oldest_result.dest_count, rsp_if.dest_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d answers outstanding", $time,
               quiet_cycles, pending_scan_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  // A fresh table: nothing to find and nothing to count, from either end.
  task automatic test_cleared_table();
    send_request(REQ_FIND, 16'h0000, 8'h00);
    send_request(REQ_COUNT, 16'h0000, 8'hFF);
    send_request(REQ_COUNT, 16'hFFFF, 8'h00);
    send_request(REQ_FIND, 16'hFFFF, 8'hFF);
  endtask

  // Marks at both ends and the middle, assembled entries skipped by a search,
  // marks that touch neither tracked flag, and an empty mark.
  task automatic test_mark_and_search();
    send_request(REQ_MARK, 16'hFFFF, DEST_BYTE);
    send_request(REQ_FIND, 16'hFFFF, 8'h00);
    send_request(REQ_COUNT, 16'hFFFF, 8'h00);
    send_request(REQ_MARK, 16'h0000, 8'hFF);
    send_request(REQ_FIND, 16'h0000, 8'h00);
    send_request(REQ_MARK, 16'h8000, DEST_BYTE);
    send_request(REQ_FIND, 16'h0001, 8'h00);
    send_request(REQ_MARK, 16'h8000, ASM_BYTE);
    send_request(REQ_FIND, 16'h8000, 8'h00);
    send_request(REQ_MARK, 16'h1234, 8'h00);
    send_request(REQ_MARK, 16'h1235, ~(DEST_BYTE | ASM_BYTE));
    send_request(REQ_MARK, 16'h7FFF, ASM_BYTE);
    send_request(REQ_MARK, 16'h7FFF, DEST_BYTE);
    send_request(REQ_COUNT, 16'h0000, 8'h00);
    send_request(REQ_FIND, 16'h7FFF, 8'h00);
  endtask

  // An unknown request must leave the table alone and answer all zeros.
  task automatic test_unknown_request();
    send_request(REQ_UNKNOWN, 16'hFFFF, 8'hFF);
    send_request(REQ_UNKNOWN, 16'h0000, 8'h00);
    send_request(REQ_COUNT, 16'hF000, 8'h00);
  endtask

  // Hold the receiver off while requests keep coming, so the output register
  // fills, the block finishes the next one and then has to stall its input.
  task automatic test_output_backpressure();
    int k;
    recv_hold_left = 300;
    for (k = 0; k < 6; k++) begin
      if (k % 2 == 0)
        send_request(REQ_MARK, hot_address(), 8'(($urandom_range(255) & ~ASM_BYTE) | DEST_BYTE));
      else
        send_request(REQ_COUNT, hot_address(), 8'($urandom_range(255)));
    end
  endtask

  // Mostly well-formed sequences: flag an entry as a destination, search and
  // count from just below it, sometimes mark it assembled, then search again.
  // The rest is noise: any request type at any address with any flags.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int first;
    int pick;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] addr;
    logic [REQ_W-1:0] kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(99) < 60) begin
        target = hot_address();
        send_request(REQ_MARK, target, 8'(($urandom_range(255) & ~ASM_BYTE) | DEST_BYTE));
        send_request(REQ_FIND, start_below(target), 8'($urandom_range(255)));
        send_request(REQ_COUNT, start_below(target), 8'($urandom_range(255)));
        if ($urandom_range(1))
          send_request(REQ_MARK, target, 8'($urandom_range(255) | ASM_BYTE));
        send_request(REQ_FIND, start_below(target), 8'($urandom_range(255)));
      end else begin
        kind = REQ_W'($urandom_range(3));
        pick = $urandom_range(99);
        // Keep queries from low addresses rare: a scan from the bottom is slow.
        if (pick < 25)
          addr = ADDR_W'($urandom_range(16'hFFFF));
        else if (pick < 30)
          addr = 16'h0000;
        else
          addr = hot_address();
        send_request(kind, addr, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_MARK;
    req_if.address   = '0;
    req_if.flag_bits = '0;
    send_idle_pct    = 10;
    recv_idle_pct    = 79;
    recv_hold_left   = 0;
    quiet_cycles     = 0;
    error_count      = 0;
    items_sent       = 0;
    results_seen     = 0;
    n_marks          = 0;
    n_finds          = 0;
    n_find_hits      = 0;
    n_counts         = 0;
    n_unknown        = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_cleared_table();
    test_mark_and_search();
    test_unknown_request();
    test_output_backpressure();
    test_random_traffic(10, 79, 185);
    test_random_traffic(79, 10, 185);
    test_random_traffic(0, 0, 185);

    // Drop valid, drain the outstanding answers, then watch for strays.
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_scan_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb: %0d requests (%0d marks, %0d finds with %0d hits, %0d counts, %0d unknown)",
             items_sent, n_marks, n_finds, n_find_hits, n_counts, n_unknown);
    $display("tb: %0d answers checked across three stall mixes and one long hold-off",
             results_seen);
    if (error_count == 0 && pending_scan_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: address_type_flag_scanner.f
+incdir+design
design/atfs_pkg.sv
design/atfs_req_if.sv
design/atfs_rsp_if.sv
design/atfs_word_eval.sv
design/address_type_flag_scanner.sv
tb/sv/tb.sv
